>>> design/feic_pkg.sv
package feic_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_BITS     = 32;
    localparam int SIZE_BITS     = 24;
    localparam int HEADER_BYTES  = 32;
    localparam int ALIGN_BYTES   = 16;

    // derived widths
    localparam int POS_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int SPAN_W = ((SIZE_BITS > 13) ? SIZE_BITS : 13) + 2;
    localparam int CMP_W  = (ADDR_BITS > SPAN_W) ? ADDR_BITS : SPAN_W;
    localparam int SUM_W  = SIZE_BITS + 2;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRED     = 2'd1,
        ST_SUCC     = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // update broadcast to the cells
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_PRED   = 2'd1,
        OP_SUCC   = 2'd2,
        OP_INSERT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [ADDR_BITS-1:0] block_addr;
        logic [SIZE_BITS-1:0] block_size;
    } t_item;

    typedef struct packed {
        t_status    status;
        logic [3:0] entry_index;
        logic [4:0] entry_count;
    } t_result;

    typedef struct packed {
        t_cell_op             op;
        logic [ADDR_BITS-1:0] blk_addr;
        logic [SIZE_BITS-1:0] blk_size;
        logic [SPAN_W-1:0]    blk_span;
    } t_cmd;

    // what a cell hands to its right neighbor
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] size;
        logic                 lt;
    } t_link;

    typedef struct packed {
        logic lt;
        logic pred_ok;
        logic succ_ok;
    } t_cell_stat;

    // aligned payload plus header
    function automatic logic [SPAN_W-1:0] span_of(input logic [SIZE_BITS-1:0] s);
        logic [SPAN_W-1:0] ext;
        ext = SPAN_W'(s) + SPAN_W'(ALIGN_BYTES - 1);
        return SPAN_W'((ext / ALIGN_BYTES) * ALIGN_BYTES) + SPAN_W'(HEADER_BYTES);
    endfunction

    // size of two merged extents, one header reclaimed
    function automatic logic [SUM_W-1:0] merge_sum(input logic [SIZE_BITS-1:0] a,
                                                   input logic [SIZE_BITS-1:0] b);
        return SUM_W'(a) + SUM_W'(b) + SUM_W'(HEADER_BYTES);
    endfunction

endpackage

>>> design/free_extent_insert_coalesce.sv
// Address-ordered free extent table with coalescing. A beat is accepted when start is high
// and busy is low; busy then stays high while every cell compares its extent with the
// freed block in parallel and the row shifts by one place if an insert is needed. The
// result strobe o_done is high for exactly one cycle, the cycle after that, and the
// receiver cannot stall it. No new beat is taken while busy is high; a new beat may be
// accepted in the same cycle its predecessor's result shows.
module free_extent_insert_coalesce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  feic_pkg::t_item   i_item,
    output logic              o_done,
    output feic_pkg::t_result o_result
);
    import feic_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state               r_state;
    logic [POS_W-1:0]     r_count, n_count;
    logic [ADDR_BITS-1:0] r_blk_addr;
    logic [SIZE_BITS-1:0] r_blk_size;
    logic [SPAN_W-1:0]    r_blk_span;
    logic                 r_done;
    t_result              r_result, n_result;
    t_cell_op             w_op;
    t_cmd                 w_cmd;

    t_link                w_link [TABLE_ENTRIES];
    t_link                w_left [TABLE_ENTRIES];
    t_cell_stat           w_stat [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_pred_ok, w_succ_ok, w_boundary;
    logic [POS_W-1:0]     w_pos;
    logic                 w_any_boundary;

    assign busy     = (r_state == S_EVAL);
    assign o_done   = r_done;
    assign o_result = r_result;

    // command broadcast to the row
    assign w_cmd.op       = w_op;
    assign w_cmd.blk_addr = r_blk_addr;
    assign w_cmd.blk_size = r_blk_size;
    assign w_cmd.blk_span = r_blk_span;

    // row of cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '{addr: '0, size: '0, lt: 1'b1};
        end else begin : g_rest
            assign w_left[g] = w_link[g-1];
        end

        feic_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_left     (w_left[g]),
            .i_right_lt ((g == TABLE_ENTRIES - 1) ? 1'b0 : w_link[(g + 1) % TABLE_ENTRIES].lt),
            .i_occupied (POS_W'(g) < r_count),
            .o_link     (w_link[g]),
            .o_stat     (w_stat[g])
        );

        assign w_pred_ok[g]  = w_stat[g].pred_ok;
        assign w_succ_ok[g]  = w_stat[g].succ_ok;
        assign w_boundary[g] = !w_stat[g].lt && w_left[g].lt;
    end

    // insert position: first cell not below the block, or the end of a full row
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (w_boundary[i]) begin
                w_pos = w_pos | POS_W'(i);
            end
        end
        w_any_boundary = |w_boundary;
        if (!w_any_boundary) begin
            w_pos = POS_W'(TABLE_ENTRIES);
        end
    end

    // choose merge, insert or drop
    always_comb begin
        w_op     = OP_HOLD;
        n_count  = r_count;
        n_result = '{status: ST_FULL, entry_index: '0, entry_count: r_count[4:0]};
        if (r_state == S_EVAL) begin
            if (|w_pred_ok) begin
                w_op = OP_PRED;
                n_result.status      = ST_PRED;
                n_result.entry_index = 4'(w_pos - POS_W'(1));
            end else if (|w_succ_ok) begin
                w_op = OP_SUCC;
                n_result.status      = ST_SUCC;
                n_result.entry_index = 4'(w_pos);
            end else if (r_count < POS_W'(TABLE_ENTRIES)) begin
                w_op    = OP_INSERT;
                n_count = r_count + POS_W'(1);
                n_result.status      = ST_INSERTED;
                n_result.entry_index = 4'(w_pos);
                n_result.entry_count = 5'(n_count);
            end
        end
    end

    // control state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state  <= S_IDLE;
                    r_count  <= n_count;
                    r_done   <= 1'b1;
                    r_result <= n_result;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // capture the freed block
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_blk_addr <= i_item.block_addr;
            r_blk_size <= i_item.block_size;
            r_blk_span <= span_of(i_item.block_size);
        end
    end

endmodule

>>> design/feic_cell.sv
module feic_cell (
    input  logic                i_clk,
    input  feic_pkg::t_cmd      i_cmd,
    input  feic_pkg::t_link     i_left,
    input  logic                i_right_lt,
    input  logic                i_occupied,
    output feic_pkg::t_link     o_link,
    output feic_pkg::t_cell_stat o_stat
);
    import feic_pkg::*;

    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 w_lt, w_is_pos, w_is_pred, w_fits;
    logic [CMP_W-1:0]     w_end_dist, w_start_dist;
    logic [SUM_W-1:0]     w_grown;

    // position of this extent relative to the block
    assign w_lt      = i_occupied && (r_addr < i_cmd.blk_addr);
    assign w_is_pos  = !w_lt && i_left.lt;
    assign w_is_pred = w_lt && !i_right_lt;

    // adjacency and overflow checks
    assign w_end_dist   = CMP_W'(i_cmd.blk_addr - r_addr);
    assign w_start_dist = CMP_W'(r_addr - i_cmd.blk_addr);
    assign w_grown      = merge_sum(r_size, i_cmd.blk_size);
    assign w_fits       = (w_grown[SUM_W-1:SIZE_BITS] == '0);

    assign o_stat.lt      = w_lt;
    assign o_stat.pred_ok = w_is_pred && w_fits && (w_end_dist == CMP_W'(span_of(r_size)));
    assign o_stat.succ_ok = w_is_pos && i_occupied && w_fits && (r_addr > i_cmd.blk_addr)
                            && (w_start_dist == CMP_W'(i_cmd.blk_span));

    assign o_link.addr = r_addr;
    assign o_link.size = r_size;
    assign o_link.lt   = w_lt;

    // next contents: grow, replace or take the left neighbor's extent
    always_comb begin
        n_addr = r_addr;
        n_size = r_size;
        case (i_cmd.op)
            OP_PRED: begin
                if (w_is_pred) begin
                    n_size = w_grown[SIZE_BITS-1:0];
                end
            end
            OP_SUCC: begin
                if (w_is_pos) begin
                    n_addr = i_cmd.blk_addr;
                    n_size = w_grown[SIZE_BITS-1:0];
                end
            end
            OP_INSERT: begin
                if (w_is_pos) begin
                    n_addr = i_cmd.blk_addr;
                    n_size = i_cmd.blk_size;
                end else if (!w_lt) begin
                    n_addr = i_left.addr;
                    n_size = i_left.size;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_size <= n_size;
    end

endmodule
